FILE: hw/rtl/lattice_hash_noise_sample_assert.svh
// Assertion macros for the top-level RTL
`ifndef LATTICE_HASH_NOISE_SAMPLE_ASSERT_SVH
`define LATTICE_HASH_NOISE_SAMPLE_ASSERT_SVH
`ifndef SYNTHESIS
`define LHNS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define LHNS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define LHNS_ASSERT(lbl, prop)
`define LHNS_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

FILE: hw/rtl/lhns_pkg.sv
`timescale 1ns / 1ps
package lhns_pkg;

  localparam int NAXES     = 3;
  localparam int DIV_STEPS = 32;

  localparam logic [1:0] REG_CELL_SIZE  = 2'd0;
  localparam logic [1:0] REG_AMPLITUDE  = 2'd1;
  localparam logic [1:0] REG_NOISE_SEED = 2'd2;

  localparam logic [31:0] CELL_SIZE_RST = 32'h0010_0000;
  localparam logic [30:0] ONE_Q16       = 31'h0001_0000;

  localparam logic [31:0] K_GX  = 32'h9e37_79b9;
  localparam logic [31:0] K_GY  = 32'h85eb_ca6b;
  localparam logic [31:0] K_GZ  = 32'hc2b2_ae35;
  localparam logic [31:0] K_MIX1 = 32'h7feb_352d;
  localparam logic [31:0] K_MIX2 = 32'h846c_a68b;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] quo;
    logic        neg;
  } div_lane_t;

  typedef div_lane_t [NAXES-1:0] div_word_t;

  // one restoring step: shift in next dividend bit, subtract if it fits
  function automatic div_lane_t div_step(div_lane_t a, logic [30:0] d);
    logic [32:0] t;
    logic [32:0] diff;
    div_lane_t   r;
    t    = {a.rem, a.quo[31]};
    diff = t - {2'b00, d};
    r.neg = a.neg;
    if (!diff[32]) begin
      r.rem = diff[31:0];
      r.quo = {a.quo[30:0], 1'b1};
    end else begin
      r.rem = t[31:0];
      r.quo = {a.quo[30:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [31:0] mul_lo(logic [31:0] a, logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    return p[31:0];
  endfunction

endpackage

FILE: hw/rtl/lhns_div_stage.sv
`timescale 1ns / 1ps
module lhns_div_stage
  import lhns_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [30:0] divisor,
  input  logic        up_valid,
  output logic        up_ready,
  input  div_word_t   up_data,
  output logic        dn_valid,
  input  logic        dn_ready,
  output div_word_t   dn_data
);

  logic      vld_r;
  div_word_t data_r;
  div_word_t data_nxt;

  assign up_ready = !vld_r || dn_ready;

  always_comb begin
    for (int i = 0; i < NAXES; i++) begin
      data_nxt[i] = div_step(up_data[i], divisor);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

FILE: hw/rtl/lhns_hash.sv
`timescale 1ns / 1ps
module lhns_hash
  import lhns_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [63:0]        seed,
  input  logic signed [31:0] amp,
  input  logic               up_valid,
  output logic               up_ready,
  input  div_word_t          up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output logic [31:0]        dn_data
);

  localparam int NST = 6;

  logic [NST-1:0] v_r;
  logic [NST-1:0] en;

  logic [31:0]        g_r [NAXES];
  logic [31:0]        g_nxt [NAXES];
  logic [31:0]        h1_r, h1_nxt;
  logic [31:0]        h2_r, h2_nxt;
  logic [31:0]        h3_r, h3_nxt;
  logic signed [48:0] prod_r, prod_nxt;
  logic [31:0]        res_r, res_nxt;

  logic [31:0]        fold;
  logic [31:0]        mix_a, mix_b, mix_c;
  logic signed [16:0] smp;
  logic signed [48:0] adj;
  logic signed [33:0] scaled;

  always_comb begin
    for (int k = 0; k < NST - 1; k++) begin
      en[k] = !v_r[k] || en[k+1];
    end
    en[NST-1] = !v_r[NST-1] || dn_ready;
  end

  assign up_ready = en[0];

  // floor correction of the truncated magnitude quotient
  always_comb begin
    for (int i = 0; i < NAXES; i++) begin
      if (!up_data[i].neg) begin
        g_nxt[i] = up_data[i].quo;
      end else if (up_data[i].rem != 32'd0) begin
        g_nxt[i] = ~up_data[i].quo;
      end else begin
        g_nxt[i] = 32'd0 - up_data[i].quo;
      end
    end
  end

  assign fold   = seed[31:0] ^ seed[63:32];
  assign h1_nxt = fold ^ mul_lo(g_r[0], K_GX) ^ mul_lo(g_r[1], K_GY)
                  ^ mul_lo(g_r[2], K_GZ);
  assign mix_a  = h1_r ^ (h1_r >> 16);
  assign h2_nxt = mul_lo(mix_a, K_MIX1);
  assign mix_b  = h2_r ^ (h2_r >> 15);
  assign h3_nxt = mul_lo(mix_b, K_MIX2);
  assign mix_c  = h3_r ^ (h3_r >> 16);
  assign smp    = $signed({1'b0, mix_c[15:0]}) - 17'sd32768;
  assign prod_nxt = smp * amp;

  // divide by 32768, truncating toward zero, then saturate
  assign adj    = prod_r[48] ? prod_r + 49'sd32767 : prod_r;
  assign scaled = $signed(adj[48:15]);

  always_comb begin
    if (scaled[33:31] == 3'b000 || scaled[33:31] == 3'b111) begin
      res_nxt = scaled[31:0];
    end else if (!scaled[33]) begin
      res_nxt = 32'h7fff_ffff;
    end else begin
      res_nxt = 32'h8000_0000;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= up_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < NAXES; i++) begin
        g_r[i] <= g_nxt[i];
      end
    end
    if (en[1]) begin
      h1_r <= h1_nxt;
    end
    if (en[2]) begin
      h2_r <= h2_nxt;
    end
    if (en[3]) begin
      h3_r <= h3_nxt;
    end
    if (en[4]) begin
      prod_r <= prod_nxt;
    end
    if (en[5]) begin
      res_r <= res_nxt;
    end
  end

  assign dn_valid = v_r[NST-1];
  assign dn_data  = res_r;

endmodule

FILE: hw/rtl/lattice_hash_noise_sample.sv
// Hashed lattice value noise. Each request carries one Q16.16 point; the block
// floors each coordinate by the cell size, hashes the three cell indices with
// the seed and returns one scaled, saturated Q16.16 noise value per point.
// One point is taken every clock while the output is not stalled, through 39
// register stages: an input register, a 32-stage bit-per-stage divider for the
// three axes in parallel, and six hash/scale stages ending in the output
// register. A stall reaches every stage combinationally through the ready
// chain, so bubbles are squeezed out. Write configuration only while no
// request is in flight.
`timescale 1ns / 1ps
`include "lattice_hash_noise_sample_assert.svh"
module lattice_hash_noise_sample
  import lhns_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // pos_x[31:0], pos_y[63:32], pos_z[95:64]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // noise_value[31:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [31:0] cell_size_r;
  logic [31:0] amplitude_r;
  logic [63:0] noise_seed_r;
  logic [30:0] divisor;

  logic      s0_v_r;
  div_word_t s0_d_r;
  div_word_t s0_d_nxt;
  logic      s0_en;

  logic      dv_v   [DIV_STEPS+1];
  logic      dv_rdy [DIV_STEPS+1];
  div_word_t dv_d   [DIV_STEPS+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_size_r  <= CELL_SIZE_RST;
      amplitude_r  <= 32'd0;
      noise_seed_r <= 64'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CELL_SIZE:  cell_size_r  <= cfg_data[31:0];
        REG_AMPLITUDE:  amplitude_r  <= cfg_data[31:0];
        REG_NOISE_SEED: noise_seed_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign divisor = (cell_size_r[31] || cell_size_r == 32'd0) ? ONE_Q16 : cell_size_r[30:0];

  always_comb begin
    for (int i = 0; i < NAXES; i++) begin
      s0_d_nxt[i].rem = 32'd0;
      s0_d_nxt[i].neg = in_tdata[32*i+31];
      s0_d_nxt[i].quo = in_tdata[32*i+31] ? 32'd0 - in_tdata[32*i +: 32]
                                          : in_tdata[32*i +: 32];
    end
  end

  assign s0_en     = !s0_v_r || dv_rdy[0];
  assign in_tready = s0_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (s0_en) begin
      s0_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_en) begin
      s0_d_r <= s0_d_nxt;
    end
  end

  assign dv_v[0] = s0_v_r;
  assign dv_d[0] = s0_d_r;

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    lhns_div_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .divisor  (divisor),
      .up_valid (dv_v[g]),
      .up_ready (dv_rdy[g]),
      .up_data  (dv_d[g]),
      .dn_valid (dv_v[g+1]),
      .dn_ready (dv_rdy[g+1]),
      .dn_data  (dv_d[g+1])
    );
  end

  lhns_hash u_hash (
    .clk      (clk),
    .rst_n    (rst_n),
    .seed     (noise_seed_r),
    .amp      ($signed(amplitude_r)),
    .up_valid (dv_v[DIV_STEPS]),
    .up_ready (dv_rdy[DIV_STEPS]),
    .up_data  (dv_d[DIV_STEPS]),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_data  (out_tdata)
  );

  `LHNS_ASSERT(a_divisor_nonzero, divisor != 31'd0)
  `LHNS_ASSERT_IMP(a_zero_amp, out_tvalid && amplitude_r == 32'd0, out_tdata == 32'd0)
  `LHNS_ASSERT_IMP(a_rem_bound, dv_v[DIV_STEPS], dv_d[DIV_STEPS][0].rem < {1'b0, divisor})
  `LHNS_ASSERT_IMP(a_empty_accepts, !s0_v_r, in_tready)

endmodule
